// ===== sv/rk4smd_pkg.sv =====
// Package with the widths, register indexes and the saturation helper function of the spring-mass-damper step.
`timescale 1ns / 1ps
package rk4smd_pkg;
	localparam int DT_SHIFT  = 10;
	localparam int FRAC_BITS = 16;
	localparam int REG_W     = 31;
	localparam int VAL_W     = 32;
	localparam int ACC_W     = 40;
	localparam int PROD_W    = 64;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef enum logic [2:0] {
		REG_INV_MASS    = 3'd0,
		REG_INV_INERTIA = 3'd1,
		REG_STIFF_X     = 3'd2,
		REG_STIFF_Y     = 3'd3,
		REG_STIFF_ROT   = 3'd4,
		REG_DAMP_X      = 3'd5,
		REG_DAMP_Y      = 3'd6,
		REG_DAMP_ROT    = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_FULL = 2'd0,
		ACT_KIN  = 2'd1,
		ACT_VEL  = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	// Saturate a wide signed value to 32 bits.
	function automatic val_t sat_acc(input acc_t v);
		if (v > acc_t'(32'sh7fffffff)) begin
			sat_acc = 32'sh7fffffff;
		end else if (v < -acc_t'(33'sh080000000)) begin
			sat_acc = 32'sh80000000;
		end else begin
			sat_acc = v[VAL_W-1:0];
		end
	endfunction
endpackage

// ===== sv/rk4_spring_mass_damper_step.sv =====
// Top level of the spring-mass-damper time step block.
//
// An item on the slave stream carries an action code in tuser and the force pair
// and moment in tdata. The block takes one item at a time: s_tready is low from
// acceptance until the result has been taken from the master stream. The result
// carries the six state values after the step.
// The products of the stages go through one shared registered multiplier; the
// divide by six has its own constant reciprocal product. A live axis is loaded,
// then runs four stages of three products and an accumulate with a stage update
// between them, then for each increment the steps scale by dt, divide by six
// through the reciprocal product and update. A full step works on three live
// axes, a velocity-only step leaves the rotational axis out, a frozen axis is
// skipped, and kinematic and idle steps show their result the next cycle.
// Reset clears the state to zero and the registers to their reset values.
// While the receiver stalls the result is held and no new item is taken.
// Configuration writes are taken at any time but must be made while idle.
`timescale 1ns / 1ps
module rk4_spring_mass_damper_step
	import rk4smd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [30:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: force_x [31:0], force_y [63:32], moment [95:64]
	input  logic [95:0]  s_tdata,
	// tuser: action [1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: pos_x, pos_y, angle, vel_x, vel_y, ang_vel, 32 bits each from the lowest
	output logic [191:0] m_tdata
);
	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_AXIS  = 11'b00000000010,
		ST_MDAMP = 11'b00000000100,
		ST_MSTIF = 11'b00000001000,
		ST_MINV  = 11'b00000010000,
		ST_ACC   = 11'b00000100000,
		ST_STAGE = 11'b00001000000,
		ST_DIVP  = 11'b00010000000,
		ST_DIV   = 11'b00100000000,
		ST_UPD   = 11'b01000000000,
		ST_OUT   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [REG_W-1:0] regs_q [8];
	val_t pos_q [3];
	val_t vel_q [3];
	val_t force_q [3];
	action_t act_q;
	logic [1:0] axis_q;
	logic [1:0] stage_q;
	logic       mph_q;
	logic       divsel_q;
	val_t ps_q, vs_q, bal_q, kv_q, kp_q, dp_q;
	acc_t bacc_q;
	acc_t sp_q, sv_q;
	logic [ACC_W-1:0] dnum_q;
	logic       dneg_q;

	val_t mul_a;
	logic signed [VAL_W:0] mul_b;
	val_t mul_p;

	rk4smd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	logic [REG_W-1:0] damp_r, stiff_r, inv_r;
	always_comb begin
		case (axis_q)
			2'd0: begin
				damp_r = regs_q[REG_DAMP_X]; stiff_r = regs_q[REG_STIFF_X];
				inv_r = regs_q[REG_INV_MASS];
			end
			2'd1: begin
				damp_r = regs_q[REG_DAMP_Y]; stiff_r = regs_q[REG_STIFF_Y];
				inv_r = regs_q[REG_INV_MASS];
			end
			default: begin
				damp_r = regs_q[REG_DAMP_ROT]; stiff_r = regs_q[REG_STIFF_ROT];
				inv_r = regs_q[REG_INV_INERTIA];
			end
		endcase
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		case (state_q)
			ST_MSTIF: begin mul_a = ps_q;    mul_b = {2'b00, stiff_r}; end
			ST_MINV:  begin mul_a = bal_q;   mul_b = {2'b00, inv_r};   end
			default:  begin mul_a = vs_q;    mul_b = {2'b00, damp_r};  end
		endcase
	end

	// Stage shift: half steps for the second and third stage input.
	logic [4:0] sh;
	assign sh = (stage_q == 2'd3) ? 5'(DT_SHIFT) : 5'(DT_SHIFT + 1);

	logic axis_en;
	assign axis_en = (stiff_r != '0) &&
		((axis_q != 2'd2) || (act_q == ACT_FULL));

	acc_t bal_w, sum_w, dval, dabs;
	logic [63:0] dprod_w;

	// The magnitude after the dt scaling stays below 2^32, where the reciprocal
	// of six with a 34-bit shift gives the exact truncated quotient.
	always_comb begin
		bal_w = bacc_q - acc_t'(mul_p);
		sum_w = divsel_q ? sv_q : sp_q;
		dval = sum_w >>> DT_SHIFT;
		dabs = dval[ACC_W-1] ? -dval : dval;
		dprod_w = 64'(dnum_q[31:0]) * 64'hAAAAAAAB;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata = {vel_q[2], vel_q[1], vel_q[0], pos_q[2], pos_q[1], pos_q[0]};

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) regs_q[i] <= '0;
			regs_q[REG_INV_MASS] <= REG_W'(1 << FRAC_BITS);
			regs_q[REG_INV_INERTIA] <= REG_W'(1 << FRAC_BITS);
		end else if (cfg_we) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0; vel_q[i] <= '0; force_q[i] <= '0;
			end
			axis_q <= '0; stage_q <= '0; mph_q <= 1'b0; divsel_q <= 1'b0;
			act_q <= ACT_FULL;
			ps_q <= '0; vs_q <= '0; bal_q <= '0; kv_q <= '0; kp_q <= '0; dp_q <= '0;
			bacc_q <= '0; sp_q <= '0; sv_q <= '0; dnum_q <= '0; dneg_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (s_tvalid) begin
					force_q[0] <= s_tdata[31:0];
					force_q[1] <= s_tdata[63:32];
					force_q[2] <= s_tdata[95:64];
					act_q <= action_t'(s_tuser);
					axis_q <= '0;
					if (action_t'(s_tuser) == ACT_KIN) begin
						if (regs_q[REG_STIFF_X] != '0)
							pos_q[0] <= sat_acc(acc_t'(pos_q[0]) + acc_t'(vel_q[0] >>> DT_SHIFT));
						if (regs_q[REG_STIFF_Y] != '0)
							pos_q[1] <= sat_acc(acc_t'(pos_q[1]) + acc_t'(vel_q[1] >>> DT_SHIFT));
						state_q <= ST_OUT;
					end else if (action_t'(s_tuser) == ACT_NONE) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_AXIS;
					end
				end
				ST_AXIS: begin
					if (axis_en) begin
						ps_q <= pos_q[axis_q]; vs_q <= vel_q[axis_q];
						stage_q <= '0; sp_q <= '0; sv_q <= '0; mph_q <= 1'b0;
						state_q <= ST_MDAMP;
					end else if (axis_q == 2'd2) begin
						state_q <= ST_OUT;
					end else begin
						axis_q <= axis_q + 2'd1;
					end
				end
				ST_MDAMP: begin
					// The force balance is kept wide and saturated once at the end.
					mph_q <= ~mph_q;
					if (mph_q) begin
						bacc_q <= acc_t'(force_q[axis_q]) - (acc_t'(mul_p) <<< 1);
						state_q <= ST_MSTIF;
					end
				end
				ST_MSTIF: begin
					mph_q <= ~mph_q;
					if (mph_q) begin
						bal_q <= sat_acc(bal_w);
						state_q <= ST_MINV;
					end
				end
				ST_MINV: begin
					mph_q <= ~mph_q;
					if (mph_q) begin
						kv_q <= mul_p; kp_q <= vs_q;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					// Weighted sums: middle stages count twice.
					if (stage_q == 2'd1 || stage_q == 2'd2) begin
						sp_q <= sp_q + (acc_t'(kp_q) <<< 1);
						sv_q <= sv_q + (acc_t'(kv_q) <<< 1);
					end else begin
						sp_q <= sp_q + acc_t'(kp_q);
						sv_q <= sv_q + acc_t'(kv_q);
					end
					if (stage_q == 2'd3) begin
						divsel_q <= 1'b0;
						state_q <= ST_DIVP;
					end else begin
						stage_q <= stage_q + 2'd1;
						state_q <= ST_STAGE;
					end
				end
				ST_STAGE: begin
					// Next stage point from the original state and the last slopes.
					vs_q <= sat_acc(acc_t'(vel_q[axis_q]) + (acc_t'(kv_q) >>> sh));
					ps_q <= sat_acc(acc_t'(pos_q[axis_q]) + (acc_t'(kp_q) >>> sh));
					state_q <= ST_MDAMP;
				end
				ST_DIVP: begin
					dnum_q <= dabs; dneg_q <= dval[ACC_W-1];
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// Division of the magnitude by six through its reciprocal.
					dnum_q <= ACC_W'(dprod_w[63:34]);
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (!divsel_q) begin
						dp_q <= sat_acc(dneg_q ? -acc_t'(dnum_q) : acc_t'(dnum_q));
						divsel_q <= 1'b1;
						state_q <= ST_DIVP;
					end else begin
						if (act_q == ACT_FULL)
							pos_q[axis_q] <= sat_acc(acc_t'(pos_q[axis_q]) + acc_t'(dp_q));
						vel_q[axis_q] <= sat_acc(acc_t'(vel_q[axis_q]) +
							(dneg_q ? -acc_t'(dnum_q) : acc_t'(dnum_q)));
						if (axis_q == 2'd2) state_q <= ST_OUT;
						else begin
							axis_q <= axis_q + 2'd1;
							state_q <= ST_AXIS;
						end
					end
				end
				ST_OUT: if (m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_ready_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("ready while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |=> state_q == ST_UPD) else $error("divider not finished");
endmodule

// ===== sv/rk4smd_mul.sv =====
// Registered signed 32 by 33 multiplier with Q-format truncation and saturation.
`timescale 1ns / 1ps
module rk4smd_mul
	import rk4smd_pkg::*;
(
	input  logic clk,
	input  val_t a,
	input  logic signed [VAL_W:0] b,
	output val_t p
);
	logic signed [PROD_W:0] prod_q;

	// Product registered; shift and saturate on the way out.
	always_ff @(posedge clk) begin
		prod_q <= (PROD_W+1)'(a) * (PROD_W+1)'(b);
	end

	logic signed [PROD_W:0] shr;
	always_comb begin
		shr = prod_q >>> FRAC_BITS;
		if (shr > (PROD_W+1)'(32'sh7fffffff)) begin
			p = 32'sh7fffffff;
		end else if (shr < -(PROD_W+1)'(33'sh080000000)) begin
			p = 32'sh80000000;
		end else begin
			p = shr[VAL_W-1:0];
		end
	end
endmodule
